// ===== design/rgc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared widths, the log2 ratio table and pipeline control types for the
// RGB gamma correction block.
// ----------------------------------------------------------------------------
package rgc_pkg;

  localparam int PIX_W       = 8;              // channel width
  localparam int G_W         = 16;             // gamma register width, Q4.12
  localparam int Q_FRAC      = 12;             // gamma fraction bits
  localparam int LG_FRAC     = 30;             // log2 fraction bits
  localparam int LG_W        = LG_FRAC + 3;    // Q3.30 covers lg(255)
  localparam int RHS_W       = G_W + LG_W;     // gamma * log ratio
  localparam int TAB_N       = 1 << PIX_W;
  localparam int SRCH_STAGES = PIX_W;          // one result bit per stage
  localparam int STAGES      = SRCH_STAGES + 2;

  localparam logic [G_W-1:0] GAMMA_RESET = G_W'(1 << Q_FRAC);  // 1.0

  typedef logic [LG_W-1:0] lr_tab_t [TAB_N];

  typedef struct packed {
    logic [STAGES-1:0] load;   // stage i takes a new word this cycle
  } rgc_ctl_t;

  // log2(k), Q.30, squaring the mantissa with truncation each step.
  // Elaboration only.
  function automatic logic [LG_W-1:0] lg_q30(input int unsigned k);
    logic [63:0] m;
    logic [63:0] r;
    int unsigned e;
    int          i;
    e = 0;
    for (i = 0; i < PIX_W - 1; i++) begin
      if ((k >> (i + 1)) != 0) e = i + 1;
    end
    m = 64'(k) << (LG_FRAC - e);
    r = 64'(e) << LG_FRAC;
    for (i = 1; i <= LG_FRAC; i++) begin
      m = (m * m) >> LG_FRAC;
      if (m >= (64'd2 << LG_FRAC)) begin
        m = m >> 1;
        r = r | (64'd1 << (LG_FRAC - i));
      end
    end
    return LG_W'(r);
  endfunction

  // lg(255) - lg(k); the entry for zero is never used.
  function automatic lr_tab_t build_lr_tab();
    lr_tab_t          t;
    logic [LG_W-1:0] top;
    int               k;
    top  = lg_q30(TAB_N - 1);
    t[0] = '0;
    for (k = 1; k < TAB_N; k++) begin
      t[k] = top - lg_q30(k);
    end
    return t;
  endfunction

  localparam lr_tab_t LR_TAB = build_lr_tab();

  function automatic logic [LG_W-1:0] lr_of(input logic [PIX_W-1:0] k);
    return LR_TAB[k];
  endfunction

endpackage

// ===== design/rgc_ifs.sv =====
// ----------------------------------------------------------------------------
// rgc pixel channels
// Valid/ready channels carrying one RGB pixel word in and one out.
// ----------------------------------------------------------------------------
interface rgc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rgc_pkg::PIX_W-1:0] red_in;
  logic [rgc_pkg::PIX_W-1:0] green_in;
  logic [rgc_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rgc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rgc_pkg::PIX_W-1:0] red_out;
  logic [rgc_pkg::PIX_W-1:0] green_out;
  logic [rgc_pkg::PIX_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== design/rgb_gamma_correction.sv =====
// ----------------------------------------------------------------------------
// rgb_gamma_correction
// Per-channel gamma correction of 8-bit RGB pixels, y = floor(255*(c/255)^g).
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and delivers one per clock at full rate while
// the output is not stalled. Each word passes a log table lookup stage, a gamma
// multiply stage and the stages of the bitwise search of the result, one output
// bit per stage through the log table. A stalled output holds the last stage;
// the words behind it keep moving into bubbles, and the input stalls only once
// no bubble is left. Gamma is Q4.12 (4096 = 1.0, reset value); the user must
// write it through cfg_wr_en/cfg_wr_data only while the pipe is empty, which
// the block itself does not enforce. Gamma 0 gives 255 on all channels; a zero
// channel otherwise gives 0. Results are within 1 LSB of the exact real mapping.
// ----------------------------------------------------------------------------
module rgb_gamma_correction (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [rgc_pkg::G_W-1:0] cfg_wr_data,
  rgc_in_if.sink                  in_pix,
  rgc_out_if.source               out_pix
);

  logic [rgc_pkg::G_W-1:0] gamma_r;
  rgc_pkg::rgc_ctl_t       ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= rgc_pkg::GAMMA_RESET;
    end else if (cfg_wr_en) begin
      gamma_r <= cfg_wr_data;
    end
  end

  rgc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .ctl       (ctl)
  );

  rgc_lane u_red (
    .clk   (clk),
    .ctl   (ctl),
    .gamma (gamma_r),
    .c_in  (in_pix.red_in),
    .y_out (out_pix.red_out)
  );

  rgc_lane u_green (
    .clk   (clk),
    .ctl   (ctl),
    .gamma (gamma_r),
    .c_in  (in_pix.green_in),
    .y_out (out_pix.green_out)
  );

  rgc_lane u_blue (
    .clk   (clk),
    .ctl   (ctl),
    .gamma (gamma_r),
    .c_in  (in_pix.blue_in),
    .y_out (out_pix.blue_out)
  );

endmodule

// ===== design/rgc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgc_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module rgc_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rgc_pkg::rgc_ctl_t ctl
);

  logic [rgc_pkg::STAGES-1:0] valid_r;
  logic [rgc_pkg::STAGES-1:0] valid_nxt;
  logic [rgc_pkg::STAGES-1:0] load;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    load[rgc_pkg::STAGES-1] = !valid_r[rgc_pkg::STAGES-1] || out_ready;
    for (int i = rgc_pkg::STAGES - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load[0]) valid_nxt[0] = in_valid;
    for (int i = 1; i < rgc_pkg::STAGES; i++) begin
      if (load[i]) valid_nxt[i] = valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid_r[rgc_pkg::STAGES-1];
  assign ctl.load  = load;

`ifndef SYNTHESIS
  // words in flight track accepted minus delivered
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) == $countones($past(valid_r))
              + ($past(in_valid && in_ready) ? 1 : 0)
              - ($past(out_valid && out_ready) ? 1 : 0)))
    else $error("rgc: word count mismatch");

  // a held word never drops out of its stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(valid_r & ~load) & ~valid_r) == '0))
    else $error("rgc: held word lost");

  // any bubble lets a new word in
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != '1) |-> in_ready)
    else $error("rgc: stalled with a bubble");
`endif

endmodule

// ===== design/rgc_lane.sv =====
// ----------------------------------------------------------------------------
// rgc_lane
// One color channel: log ratio lookup, gamma multiply, then a bitwise search
// for the largest y with 4096*LR(y) >= gamma*LR(c), one bit per stage.
// ----------------------------------------------------------------------------
module rgc_lane (
  input  logic                      clk,
  input  rgc_pkg::rgc_ctl_t         ctl,
  input  logic [rgc_pkg::G_W-1:0]   gamma,
  input  logic [rgc_pkg::PIX_W-1:0] c_in,
  output logic [rgc_pkg::PIX_W-1:0] y_out
);

  localparam int NS = rgc_pkg::SRCH_STAGES;

  // stage 0: table lookup
  logic [rgc_pkg::LG_W-1:0]  lr_r;
  logic                      kill0_r;
  // stage 1: product
  logic [rgc_pkg::RHS_W-1:0] rhs_r;
  logic                      kill1_r;
  // search stages
  logic [rgc_pkg::PIX_W-1:0] y_r    [NS];
  logic [rgc_pkg::RHS_W-1:0] rhs_s_r[NS];
  logic                      kill_s_r[NS];

  logic [rgc_pkg::RHS_W-1:0] rhs_nxt;

  // zero channel with nonzero gamma: LR is infinite, only y = 0 qualifies
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      lr_r    <= rgc_pkg::lr_of(c_in);
      kill0_r <= (c_in == '0) && (gamma != '0);
    end
  end

  assign rhs_nxt = {{rgc_pkg::LG_W{1'b0}}, gamma} * {{rgc_pkg::G_W{1'b0}}, lr_r};

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      rhs_r   <= rhs_nxt;
      kill1_r <= kill0_r;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_srch
    localparam int B = rgc_pkg::PIX_W - 1 - j;

    logic [rgc_pkg::PIX_W-1:0] y_prev;
    logic [rgc_pkg::RHS_W-1:0] rhs_prev;
    logic                      kill_prev;
    logic [rgc_pkg::PIX_W-1:0] trial;
    logic [rgc_pkg::RHS_W-1:0] lhs;
    logic                      take;

    if (j == 0) begin : g_first
      assign y_prev    = '0;
      assign rhs_prev  = rhs_r;
      assign kill_prev = kill1_r;
    end else begin : g_next
      assign y_prev    = y_r[j-1];
      assign rhs_prev  = rhs_s_r[j-1];
      assign kill_prev = kill_s_r[j-1];
    end

    always_comb begin
      trial    = y_prev;
      trial[B] = 1'b1;
      lhs      = rgc_pkg::RHS_W'(rgc_pkg::lr_of(trial)) << rgc_pkg::Q_FRAC;
      take     = !kill_prev && (lhs >= rhs_prev);
    end

    always_ff @(posedge clk) begin
      if (ctl.load[j+2]) begin
        y_r[j]      <= take ? trial : y_prev;
        rhs_s_r[j]  <= rhs_prev;
        kill_s_r[j] <= kill_prev;
      end
    end
  end

  assign y_out = y_r[NS-1];

endmodule
